// File: rtl/core/rccs_pkg.sv
// Package for the regen current clamp sequencer.
// Holds field widths, configuration register indexes and the speed tier codes.
// No dependencies.
`default_nettype none

package rccs_pkg;

  // Field widths
  localparam int unsigned CodeW     = 10;
  localparam int unsigned SpeedW    = 8;
  localparam int unsigned CurrentW  = 16;
  localparam int unsigned CountW    = 8;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;
  // -(a + b) of two 16-bit signed values fits in 18 bits signed.
  localparam int unsigned RegenW    = CurrentW + 2;

  // Full-scale value of the DAC that the tier fractions refer to.
  localparam int unsigned DAC_FULL_SCALE = 1023;
  localparam int unsigned CodeMax        = (1 << CodeW) - 1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegZoneLimit  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDacOff     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegFloor      = 3'd2;
  localparam logic [CfgIdxW-1:0] RegHardCapCnt = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMaxCode    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegInitCap    = 3'd5;

  // Register reset values
  localparam logic [CodeW-1:0]    ZoneLimitRst = 10'd0;
  localparam logic [CodeW-1:0]    DacOffRst    = 10'd1023;
  localparam logic [CurrentW-1:0] FloorRst     = 16'd0;
  localparam logic [CountW-1:0]   HardCapRst   = 8'd0;
  localparam logic [CodeW-1:0]    MaxCodeRst   = 10'd1023;
  localparam logic [CodeW-1:0]    InitCapRst   = 10'd102;

  // Speed tier boundaries in km/h
  localparam logic [SpeedW-1:0] SpeedHigh = 8'd75;
  localparam logic [SpeedW-1:0] SpeedMid  = 8'd50;
  localparam logic [SpeedW-1:0] SpeedLow  = 8'd30;

  // Rounded full-scale fraction in tenths, saturated to the code range.
  function automatic logic [CodeW-1:0] tier_calc(input int unsigned tenths);
    int unsigned code;
    code = (DAC_FULL_SCALE * tenths + 5) / 10;
    if (code > CodeMax) begin
      code = CodeMax;
    end
    return code[CodeW-1:0];
  endfunction

  localparam logic [CodeW-1:0] TierCodeHigh = tier_calc(1);
  localparam logic [CodeW-1:0] TierCodeMid  = tier_calc(4);
  localparam logic [CodeW-1:0] TierCodeLow  = tier_calc(7);
  localparam logic [CodeW-1:0] TierCodeFull = tier_calc(10);

endpackage

`default_nettype wire

// File: rtl/core/regen_current_clamp_sequencer_unit.sv
// Regen current clamp sequencer: top level with the clamp state machine.
// A word accepted into the input register moves into the result register,
// with out_valid_o high, once that is free; one word per cycle passes when
// the result is not stalled. The input register and the result register
// each hold one word, so a stalled result stops intake only once both are full.
// Reset (rst_ni low, asynchronous) clears both stages, puts the clamp in idle
// with a zero sample count and loads all configuration registers with defaults.
// Depends on rccs_pkg.
`default_nettype none

module regen_current_clamp_sequencer_unit
  import rccs_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // Configuration write port
  input  wire logic                       cfg_we_i,
  input  wire logic [CfgIdxW-1:0]         cfg_idx_i,
  input  wire logic [CfgDataW-1:0]        cfg_wdata_i,
  // Input word
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [CodeW-1:0]           throttle_code_i,
  input  wire logic [SpeedW-1:0]          speed_kmh_i,
  input  wire logic signed [CurrentW-1:0] battery_current_i,
  input  wire logic signed [CurrentW-1:0] solar_current_i,
  // Result word
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [CodeW-1:0]                regen_dac_o
);

  typedef enum logic [1:0] {
    PhIdle = 2'd0,
    PhHard = 2'd1,
    PhDyn  = 2'd2
  } phase_e;

  // Configuration registers
  logic [CodeW-1:0]           zone_limit_q;
  logic [CodeW-1:0]           dac_off_q;
  logic signed [CurrentW-1:0] floor_q;
  logic [CountW-1:0]          hard_cap_q;
  logic [CodeW-1:0]           max_code_q;
  logic [CodeW-1:0]           init_cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_limit_q <= ZoneLimitRst;
      dac_off_q    <= DacOffRst;
      floor_q      <= FloorRst;
      hard_cap_q   <= HardCapRst;
      max_code_q   <= MaxCodeRst;
      init_cap_q   <= InitCapRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegZoneLimit:  zone_limit_q <= cfg_wdata_i[CodeW-1:0];
        RegDacOff:     dac_off_q    <= cfg_wdata_i[CodeW-1:0];
        RegFloor:      floor_q      <= cfg_wdata_i;
        RegHardCapCnt: hard_cap_q   <= cfg_wdata_i[CountW-1:0];
        RegMaxCode:    max_code_q   <= cfg_wdata_i[CodeW-1:0];
        RegInitCap:    init_cap_q   <= cfg_wdata_i[CodeW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake between the two stages
  logic s1_valid_q;
  logic out_valid_q;
  logic advance;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;

  // Input register
  logic [CodeW-1:0]           throttle_q;
  logic [SpeedW-1:0]          speed_q;
  logic signed [CurrentW-1:0] batt_q;
  logic signed [CurrentW-1:0] sol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      throttle_q <= throttle_code_i;
      speed_q    <= speed_kmh_i;
      batt_q     <= battery_current_i;
      sol_q      <= solar_current_i;
    end
  end

  // Regen current, zeroed below the floor
  logic signed [RegenW-1:0] regen_raw;
  logic signed [RegenW-1:0] regen_adj;
  logic signed [RegenW-1:0] floor_ext;
  logic                     out_of_zone;
  logic [CodeW-1:0]         tier_code;

  assign floor_ext   = RegenW'(floor_q);
  assign regen_raw   = -(RegenW'(batt_q) + RegenW'(sol_q));
  assign regen_adj   = (regen_raw < floor_ext) ? '0 : regen_raw;
  assign out_of_zone = throttle_q > zone_limit_q;

  // Speed tier lookup
  always_comb begin
    if (speed_q >= SpeedHigh) begin
      tier_code = TierCodeHigh;
    end else if (speed_q >= SpeedMid) begin
      tier_code = TierCodeMid;
    end else if (speed_q >= SpeedLow) begin
      tier_code = TierCodeLow;
    end else begin
      tier_code = TierCodeFull;
    end
  end

  // Clamp state machine next values
  phase_e            phase_q, phase_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CodeW-1:0]  cap_q, cap_d;
  logic [CodeW-1:0]  result_d;

  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    cap_d    = cap_q;
    if (out_of_zone) begin
      phase_d = PhIdle;
      cap_d   = init_cap_q;
    end else begin
      case (phase_q)
        PhIdle: begin
          phase_d = PhHard;
          cap_d   = tier_code;
          count_d = '0;
        end
        PhHard: begin
          if (count_q < hard_cap_q) begin
            cap_d = tier_code;
          end else begin
            cap_d   = max_code_q;
            phase_d = PhDyn;
          end
          count_d = count_q + CountW'(1);
        end
        PhDyn: begin
          if (regen_adj <= floor_ext) begin
            phase_d = PhIdle;
          end
          count_d = '0;
        end
        default: ;
      endcase
    end
    result_d = out_of_zone ? dac_off_q : cap_d;
  end

  // State and result register
  logic [CodeW-1:0] result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      count_q     <= '0;
      cap_q       <= InitCapRst;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        phase_q <= phase_d;
        count_q <= count_d;
        cap_q   <= cap_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign regen_dac_o = result_q;

  // An out-of-zone word yields the off code and sends the clamp to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s1_valid_q && out_of_zone) |=>
      (out_valid_o && regen_dac_o == $past(dac_off_q) && phase_q == PhIdle))
    else $error("out-of-zone word did not give the off code");

  // Leaving idle always restarts the hard-cap count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s1_valid_q && !out_of_zone && phase_q == PhIdle) |=>
      (phase_q == PhHard && count_q == '0))
    else $error("idle exit did not start the hard-cap phase");

  // A full pipe with a stalled result must refuse new words.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted while both stages are full and stalled");

  // Clamp state only moves when a word passes into the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance && s1_valid_q) |=> ($stable(phase_q) && $stable(count_q) && $stable(cap_q)))
    else $error("clamp state changed without a word");

endmodule

`default_nettype wire

// File: sim/regen_current_clamp_sequencer_unit_test.sv
// Self-checking testbench for regen_current_clamp_sequencer_unit.
// Holds a scoreboard class that predicts each regen DAC word, and the tasks that drive
// the block. Depends on rccs_pkg and the block's RTL.
`timescale 1ns / 1ps

module regen_current_clamp_sequencer_unit_test;
  import rccs_pkg::*;

  // Register indexes that the block ignores
  localparam logic [CfgIdxW-1:0] RegSpare6 = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpare7 = 3'd7;
  localparam int unsigned        RegCount  = 1 << CfgIdxW;

  typedef enum logic [1:0] {
    CLAMP_IDLE = 2'd0,
    CLAMP_HARD = 2'd1,
    CLAMP_DYN  = 2'd2
  } clamp_phase_e;

  typedef struct {
    logic [CodeW-1:0]           zone_limit;
    logic [CodeW-1:0]           dac_off;
    logic signed [CurrentW-1:0] regen_floor;
    logic [CountW-1:0]          hard_cap_len;
    logic [CodeW-1:0]           max_code;
    logic [CodeW-1:0]           init_cap;
  } clamp_settings_t;

  // Tracks the clamp state and the queue of DAC words still to come out.
  class clamp_code_tracker;
    logic [CodeW-1:0]           zone_limit;
    logic [CodeW-1:0]           dac_off;
    logic signed [CurrentW-1:0] regen_floor;
    logic [CountW-1:0]          hard_cap_len;
    logic [CodeW-1:0]           max_code;
    logic [CodeW-1:0]           init_cap;
    clamp_phase_e               phase;
    logic [CountW-1:0]          sample_count;
    logic [CodeW-1:0]           cap_code;
    logic [CodeW-1:0]           expected_dac_q[$];
    int                         mismatches;

    function new();
      zone_limit   = ZoneLimitRst;
      dac_off      = DacOffRst;
      regen_floor  = FloorRst;
      hard_cap_len = HardCapRst;
      max_code     = MaxCodeRst;
      init_cap     = InitCapRst;
      phase        = CLAMP_IDLE;
      sample_count = '0;
      cap_code     = InitCapRst;
      mismatches   = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        RegZoneLimit:  zone_limit   = data[CodeW-1:0];
        RegDacOff:     dac_off      = data[CodeW-1:0];
        RegFloor:      regen_floor  = data;
        RegHardCapCnt: hard_cap_len = data[CountW-1:0];
        RegMaxCode:    max_code     = data[CodeW-1:0];
        RegInitCap:    init_cap     = data[CodeW-1:0];
        default: ;
      endcase
    endfunction

    // Rounded fraction of full scale for the speed tier, saturated to the code range.
    function logic [CodeW-1:0] speed_tier_dac(logic [SpeedW-1:0] spd);
      int unsigned tenths;
      int unsigned code;
      if (spd >= 75) begin
        tenths = 1;
      end else if (spd >= 50) begin
        tenths = 4;
      end else if (spd >= 30) begin
        tenths = 7;
      end else begin
        tenths = 10;
      end
      code = (DAC_FULL_SCALE * tenths + 5) / 10;
      return (code > CodeMax) ? CodeW'(CodeMax) : CodeW'(code);
    endfunction

    // Advances the clamp by one accepted sample and queues the DAC word it yields.
    function void note_input(logic [CodeW-1:0] thr, logic [SpeedW-1:0] spd,
                             logic signed [CurrentW-1:0] batt,
                             logic signed [CurrentW-1:0] sol);
      logic signed [RegenW-1:0] regen;
      if (thr > zone_limit) begin
        phase    = CLAMP_IDLE;
        cap_code = init_cap;
        expected_dac_q.push_back(dac_off);
        return;
      end
      regen = batt;
      regen = -(regen + sol);
      if (regen < regen_floor) begin
        regen = '0;
      end
      case (phase)
        CLAMP_IDLE: begin
          phase        = CLAMP_HARD;
          cap_code     = speed_tier_dac(spd);
          sample_count = '0;
        end
        CLAMP_HARD: begin
          if (sample_count < hard_cap_len) begin
            cap_code = speed_tier_dac(spd);
          end else begin
            cap_code = max_code;
            phase    = CLAMP_DYN;
          end
          sample_count = sample_count + 1'b1;
        end
        CLAMP_DYN: begin
          // The cap is kept for the sample that ends the dynamic phase.
          if (regen <= regen_floor) begin
            phase = CLAMP_IDLE;
          end
          sample_count = '0;
        end
        default: ;
      endcase
      expected_dac_q.push_back(cap_code);
    endfunction

    function void check_result(logic [CodeW-1:0] dac);
      logic [CodeW-1:0] want;
      if (expected_dac_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: unexpected result word, regen_dac=%0d", $time, dac);
        end
        return;
      end
      want = expected_dac_q.pop_front();
      if (dac !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: regen_dac mismatch, expected %0d, got %0d", $time, want, dac);
        end
      end
    endfunction

    function int pending();
      return expected_dac_q.size();
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]         cfg_idx_i = '0;
  logic [CfgDataW-1:0]        cfg_wdata_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic [CodeW-1:0]           throttle_code_i = '0;
  logic [SpeedW-1:0]          speed_kmh_i = '0;
  logic signed [CurrentW-1:0] battery_current_i = '0;
  logic signed [CurrentW-1:0] solar_current_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic [CodeW-1:0]           regen_dac_o;

  clamp_code_tracker tracker = new();

  // Sender burst control and the request for a long result stall
  bit bursts_on = 1'b1;
  int burst_left = 0;
  logic hold_off_req = 1'b0;

  regen_current_clamp_sequencer_unit i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .throttle_code_i   (throttle_code_i),
    .speed_kmh_i       (speed_kmh_i),
    .battery_current_i (battery_current_i),
    .solar_current_i   (solar_current_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .regen_dac_o       (regen_dac_o)
  );

  always #4 clk_i = ~clk_i;

  // Offers one input word and waits until it is accepted; gaps fall between bursts.
  task automatic send_word(input logic [CodeW-1:0] thr, input logic [SpeedW-1:0] spd,
                           input logic signed [CurrentW-1:0] batt,
                           input logic signed [CurrentW-1:0] sol);
    if (bursts_on && burst_left <= 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    in_valid_i        <= 1'b1;
    throttle_code_i   <= thr;
    speed_kmh_i       <= spd;
    battery_current_i <= batt;
    solar_current_i   <= sol;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_input(thr, spd, batt, sol);
    burst_left--;
  endtask

  // Stops offering words until every expected word has come out.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.pending() != 0);
  endtask

  function automatic logic [CfgDataW-1:0] pad_code(logic [CodeW-1:0] v, bit junk);
    return {junk ? 6'($urandom) : 6'd0, v};
  endfunction

  // Writes every register, the ignored indexes too; the block must be idle.
  task automatic apply_settings(input clamp_settings_t s, input bit junk);
    logic [CfgDataW-1:0] data [RegCount];
    data[RegZoneLimit]  = pad_code(s.zone_limit, junk);
    data[RegDacOff]     = pad_code(s.dac_off, junk);
    data[RegFloor]      = s.regen_floor;
    data[RegHardCapCnt] = {junk ? 8'($urandom) : 8'd0, s.hard_cap_len};
    data[RegMaxCode]    = pad_code(s.max_code, junk);
    data[RegInitCap]    = pad_code(s.init_cap, junk);
    data[RegSpare6]     = 16'($urandom);
    data[RegSpare7]     = 16'($urandom);
    for (int i = 0; i < RegCount; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= CfgIdxW'(i);
      cfg_wdata_i <= data[i];
      @(posedge clk_i);
      tracker.write_reg(CfgIdxW'(i), data[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic clamp_settings_t random_settings();
    clamp_settings_t s;
    s.zone_limit = 10'($urandom_range(200, 1023));
    s.dac_off    = 10'($urandom);
    case ($urandom_range(0, 2))
      0:       s.regen_floor = 16'($urandom);
      1:       s.regen_floor = 16'(int'($urandom_range(0, 1000)) - 500);
      default: s.regen_floor = '0;
    endcase
    s.hard_cap_len = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 6)) : 8'($urandom);
    s.max_code     = 10'($urandom);
    s.init_cap     = 10'($urandom);
    return s;
  endfunction

  // One random sample: mostly inside the regen zone, with currents often aimed near or above the floor.
  task automatic random_word(input clamp_settings_t s, input int out_pct);
    logic [SpeedW-1:0]          speed_edges [8] = '{0, 29, 30, 49, 50, 74, 75, 255};
    logic signed [CurrentW-1:0] current_edges [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
    logic [CodeW-1:0]           thr;
    logic [SpeedW-1:0]          spd;
    logic signed [CurrentW-1:0] batt;
    logic signed [CurrentW-1:0] sol;
    int                         sel;
    int                         target;
    int                         half;
    if (s.zone_limit < CodeMax && $urandom_range(0, 99) < out_pct) begin
      thr = 10'($urandom_range(int'(s.zone_limit) + 1, CodeMax));
    end else if ($urandom_range(0, 9) == 0) begin
      thr = s.zone_limit;
    end else begin
      thr = 10'($urandom_range(0, s.zone_limit));
    end
    spd = ($urandom_range(0, 9) < 3) ? speed_edges[$urandom_range(0, 7)] : 8'($urandom);
    sel = $urandom_range(0, 9);
    if (sel <= 2) begin
      batt = 16'($urandom);
      sol  = 16'($urandom);
    end else if (sel == 3) begin
      batt = current_edges[$urandom_range(0, 3)];
      sol  = current_edges[$urandom_range(0, 3)];
    end else begin
      if (sel <= 5) begin
        target = int'(s.regen_floor) + int'($urandom_range(0, 4)) - 2;
      end else begin
        target = int'(s.regen_floor) + int'($urandom_range(1, 3000));
      end
      half = -(target / 2);
      batt = 16'(half);
      sol  = 16'(-target - half);
    end
    send_word(thr, spd, batt, sol);
  endtask

  // Result side: checks accepted words and stalls on a changing pattern.
  initial begin : result_sink
    int   mode;
    int   mode_left;
    int   hold_left;
    bit   hold_taken;
    int   tick;
    logic [7:0] mask;
    mode       = 0;
    mode_left  = 0;
    hold_left  = 0;
    hold_taken = 1'b0;
    tick       = 0;
    mask       = 8'hA5;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        tracker.check_result(regen_dac_o);
      end
      tick++;
      if (hold_off_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = 300;
      end
      if (mode_left <= 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 96);
        mask      = 8'($urandom);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= ($urandom_range(0, 99) < 70);
          2:       out_ready_i <= mask[tick % 8];
          default: out_ready_i <= ($urandom_range(0, 99) < 25);
        endcase
      end
    end
  end

  // Generous bound on the run time: if it is reached, the run reports a fail.
  initial begin : watchdog
    #(2_000_000);
    $display("regen_current_clamp_sequencer_unit regression: fail");
    $finish;
  end

  initial begin : stimulus
    clamp_settings_t cur;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset defaults: only throttle zero is inside the zone.
    send_word(10'd0, 8'd10, 16'sd0, 16'sd0);
    send_word(10'd1, 8'd0, 16'sd0, 16'sd0);
    send_word(10'd0, 8'd80, 16'sd0, 16'sd0);
    send_word(10'd0, 8'd0, -16'sd5, 16'sd0);
    send_word(10'd0, 8'd0, -16'sd1, -16'sd1);
    send_word(10'd0, 8'd0, 16'sd0, 16'sd0);

    // Directed walk through every phase and each speed tier edge.
    wait_drained();
    repeat (4) @(posedge clk_i);
    cur = '{10'd512, 10'd5, 16'sd100, 8'd2, 10'd900, 10'd300};
    apply_settings(cur, 1'b0);
    send_word(10'd1023, 8'd0, 16'sd0, 16'sd0);
    send_word(10'd512, 8'd0, -16'sd1000, -16'sd1000);
    send_word(10'd0, 8'd30, 16'sd0, 16'sd0);
    send_word(10'd100, 8'd50, 16'sd0, 16'sd0);
    send_word(10'd200, 8'd75, 16'sd0, 16'sd0);
    send_word(10'd300, 8'd0, 16'h8000, 16'h8000);
    send_word(10'd300, 8'd0, 16'h7FFF, 16'h7FFF);
    send_word(10'd512, 8'd255, -16'sd50, -16'sd50);
    send_word(10'd512, 8'd29, 16'sd0, 16'sd0);
    send_word(10'd512, 8'd49, 16'sd0, 16'sd0);
    send_word(10'd512, 8'd74, 16'sd0, 16'sd0);
    send_word(10'd7, 8'd0, -16'sd101, 16'sd0);
    send_word(10'd7, 8'd0, -16'sd100, 16'sd0);
    send_word(10'd513, 8'd0, 16'sd0, 16'sd0);
    send_word(10'd0, 8'd0, 16'sd0, 16'sd0);

    // Extremes: whole throttle range in zone, lowest floor, longest hard-cap phase.
    wait_drained();
    repeat (4) @(posedge clk_i);
    cur = '{10'd1023, 10'd0, 16'sh8000, 8'd255, 10'd0, 10'd0};
    apply_settings(cur, 1'b1);
    bursts_on = 1'b0;
    repeat (450) random_word(cur, 0);

    // Opposite extremes: narrowest zone and highest floor.
    wait_drained();
    repeat (4) @(posedge clk_i);
    cur = '{10'd0, 10'd1023, 16'sh7FFF, 8'd0, 10'd1023, 10'd1023};
    apply_settings(cur, 1'b0);
    bursts_on = 1'b1;
    repeat (100) random_word(cur, 5);

    // Negative floor, with one long result stall while words keep coming.
    wait_drained();
    repeat (4) @(posedge clk_i);
    cur = '{10'd700, 10'd600, -16'sd200, 8'd5, 10'd512, 10'd1};
    apply_settings(cur, 1'b1);
    for (int n = 0; n < 200; n++) begin
      if (n == 40) begin
        hold_off_req <= 1'b1;
      end
      random_word(cur, 5);
    end

    // Random settings, with an occasional full drain in the middle.
    for (int p = 0; p < 4; p++) begin
      wait_drained();
      repeat (4) @(posedge clk_i);
      cur = random_settings();
      apply_settings(cur, p[0]);
      bursts_on = p[0];
      for (int n = 0; n < 200; n++) begin
        if ($urandom_range(0, 199) == 0) begin
          wait_drained();
        end
        random_word(cur, 6);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("regen_current_clamp_sequencer_unit regression: pass");
    end else begin
      $display("regen_current_clamp_sequencer_unit regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/rccs_pkg.sv
rtl/core/regen_current_clamp_sequencer_unit.sv
sim/regen_current_clamp_sequencer_unit_test.sv
